@@ design/pbm_pkg.sv @@
// ============================================================================
// pbm_pkg
// Shared types and constants for the PBM (P4) header stream parser: field
// widths, error codes, register indexes and character codes.
// ============================================================================
`default_nettype none

package pbm_pkg;

   localparam int MAX_DIM_DEFAULT   = 4096;
   localparam int TOKEN_BUF_DEFAULT = 32;

   localparam int DIM_W      = 13;
   localparam int CAP_W      = 22;
   localparam int INDEX_W    = 21;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 22;
   localparam int ERR_W      = 3;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_WIDTH    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEIGHT   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CAPACITY = 2'd2;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
   localparam logic [ERR_W-1:0] ERR_BAD_MAGIC  = 3'd1;
   localparam logic [ERR_W-1:0] ERR_SIZE       = 3'd2;
   localparam logic [ERR_W-1:0] ERR_TOO_SMALL  = 3'd3;
   localparam logic [ERR_W-1:0] ERR_TOKEN_LONG = 3'd4;
   localparam logic [ERR_W-1:0] ERR_NO_HEADER  = 3'd5;
   localparam logic [ERR_W-1:0] ERR_INCOMPLETE = 3'd6;

   // header field being read
   localparam logic [1:0] FN_MAGIC  = 2'd0;
   localparam logic [1:0] FN_WIDTH  = 2'd1;
   localparam logic [1:0] FN_HEIGHT = 2'd2;
   localparam logic [1:0] FN_DONE   = 2'd3;

   // magic match progress
   localparam logic [1:0] MP_NONE = 2'd0;
   localparam logic [1:0] MP_P    = 2'd1;
   localparam logic [1:0] MP_P4   = 2'd2;
   localparam logic [1:0] MP_BAD  = 2'd3;

   // character codes
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_VT    = 8'd11;
   localparam logic [7:0] CH_FF    = 8'd12;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_HASH  = 8'd35;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_0     = 8'd48;
   localparam logic [7:0] CH_4     = 8'd52;
   localparam logic [7:0] CH_9     = 8'd57;
   localparam logic [7:0] CH_P     = 8'd80;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_EOS  = 1'b1;

   typedef struct packed {
      logic begun;
      logic stop;
      logic ovf;
      logic neg;
   } num_flags_type;

   typedef struct packed {
      logic               data_valid;
      logic [7:0]         data_byte;
      logic [INDEX_W-1:0] data_index;
      logic               header_good;
      logic [ERR_W-1:0]   error_code;
      logic               verdict_valid;
      logic               success;
   } rsp_type;

endpackage

`default_nettype wire

@@ design/pbm_p4_header_stream_parser.sv @@
// ============================================================================
// pbm_p4_header_stream_parser
// Parses a binary PBM (P4) header from a byte stream and routes the bitmap
// bytes that follow it, with their destination offsets.
// ============================================================================
// Usage:
//   req_* carries one request per cycle: a stream byte (req_kind = 0) or an
//   end-of-stream marker (req_kind = 1). Every request gives exactly one
//   response on rsp_*: a bitmap byte with its index when rsp_data_valid is
//   set, the header and error status, and on end of stream the verdict
//   (rsp_verdict_valid, rsp_success, rsp_error_code).
//   The response is registered; throughput is one request per cycle while
//   req_stall is low. The whole parse step (token, number and magic update
//   plus the size and capacity checks) sits between the accepted request and
//   the response register.
//   When the receiver stalls, the response register holds and a one-entry
//   skid register takes the next request; req_stall rises only when the skid
//   register is full.
//   csr_* writes expected width, height and buffer capacity; write only
//   while no request is in flight. Reset (synchronous) clears the parse
//   state and sets the registers to width 1, height 1, capacity 0.
//   After end of stream the state is kept; a new stream needs reset.
// ============================================================================
`default_nettype none

module pbm_p4_header_stream_parser
   import pbm_pkg::*;
#(
   parameter int MAX_DIM   = MAX_DIM_DEFAULT,
   parameter int TOKEN_BUF = TOKEN_BUF_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic                  req_kind,
   input  wire logic [7:0]            req_byte_value,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic                  rsp_data_valid,
   output      logic [7:0]            rsp_data_byte,
   output      logic [INDEX_W-1:0]    rsp_data_index,
   output      logic                  rsp_header_good,
   output      logic [ERR_W-1:0]      rsp_error_code,
   output      logic                  rsp_verdict_valid,
   output      logic                  rsp_success
);

   localparam int NVW  = $clog2(MAX_DIM + 1);
   localparam int PW   = NVW + 4;
   localparam int CMPW = (NVW > DIM_W) ? NVW : DIM_W;
   localparam int TLW  = $clog2(TOKEN_BUF);
   localparam int BWW  = DIM_W - 2;
   localparam int NDW  = BWW + DIM_W;
   localparam logic [TLW-1:0] TL_MAX = TLW'(TOKEN_BUF - 1);

   // configuration
   logic [DIM_W-1:0] exp_width_ff, exp_height_ff;
   logic [CAP_W-1:0] capacity_ff;

   // parse state
   logic               in_comment_ff, in_comment_in;
   logic [1:0]         field_ff, field_in;
   logic [TLW-1:0]     tok_len_ff, tok_len_in;
   logic [1:0]         magic_ff, magic_in;
   logic [NVW-1:0]     num_ff, num_in;
   num_flags_type      flags_ff, flags_in;
   logic               magic_good_ff, magic_good_in;
   logic               width_ok_ff, width_ok_in;
   logic               header_done_ff, header_done_in;
   logic               in_bitmap_ff, in_bitmap_in;
   logic [CAP_W-1:0]   stored_ff, stored_in;
   logic [CAP_W-1:0]   required_ff, required_in;
   logic [ERR_W-1:0]   error_ff, error_in;

   // response buffering
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   rsp_type result;

   logic accept, out_free;

   // end-of-token outcome and helpers
   logic [BWW-1:0]   row_bytes;
   logic [DIM_W:0]   width_round;
   logic [NDW-1:0]   need;
   logic             num_eq_width, num_eq_height, num_ok;
   logic             et_magic_good, et_width_ok, et_header_done;
   logic [CAP_W-1:0] et_required;
   logic [ERR_W-1:0] et_error;
   logic [PW-1:0]    num_next;
   logic [7:0]       ch;
   logic             is_sep;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign ch        = req_byte_value;

   assign width_round = {1'b0, exp_width_ff} + (DIM_W + 1)'(7);
   assign row_bytes   = width_round[DIM_W:3];
   assign need        = NDW'(row_bytes) * NDW'(exp_height_ff);

   assign num_ok        = !flags_ff.ovf && !(flags_ff.neg && (num_ff != '0));
   assign num_eq_width  = num_ok && (CMPW'(num_ff) == CMPW'(exp_width_ff));
   assign num_eq_height = num_ok && (CMPW'(num_ff) == CMPW'(exp_height_ff));

   assign num_next = (PW'(num_ff) << 3) + (PW'(num_ff) << 1) + PW'(ch[3:0] - CH_0[3:0]);
   assign is_sep   = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR);

   always_comb begin
      et_magic_good  = magic_good_ff;
      et_width_ok    = width_ok_ff;
      et_header_done = header_done_ff;
      et_required    = required_ff;
      et_error       = error_ff;
      case (field_ff)
         FN_MAGIC: begin
            et_magic_good = (magic_ff == MP_P4);
         end
         FN_WIDTH: begin
            et_width_ok = num_eq_width;
         end
         FN_HEIGHT: begin
            if (!magic_good_ff) begin
               et_error = ERR_BAD_MAGIC;
            end else if (!width_ok_ff || !num_eq_height) begin
               et_error = ERR_SIZE;
            end else begin
               et_required = need[CAP_W-1:0];
               if (NDW'(capacity_ff) < need) begin
                  et_error = ERR_TOO_SMALL;
               end else begin
                  et_header_done = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      logic do_end;
      logic to_data;
      logic [ERR_W-1:0] code;

      do_end  = 1'b0;
      to_data = 1'b0;
      code    = ERR_NONE;

      in_comment_in  = in_comment_ff;
      field_in       = field_ff;
      tok_len_in     = tok_len_ff;
      magic_in       = magic_ff;
      num_in         = num_ff;
      flags_in       = flags_ff;
      magic_good_in  = magic_good_ff;
      width_ok_in    = width_ok_ff;
      header_done_in = header_done_ff;
      in_bitmap_in   = in_bitmap_ff;
      stored_in      = stored_ff;
      required_in    = required_ff;
      error_in       = error_ff;
      result         = '0;

      if (req_kind == KIND_EOS) begin
         do_end = !in_bitmap_ff && (error_ff == ERR_NONE);
      end else if (error_ff == ERR_NONE) begin
         to_data = in_bitmap_ff;
         if (!in_bitmap_ff) begin
            if (in_comment_ff) begin
               if (ch == CH_LF || ch == CH_CR) begin
                  in_comment_in = 1'b0;
               end
            end else if (ch == CH_HASH) begin
               do_end        = 1'b1;
               in_comment_in = 1'b1;
            end else if (is_sep) begin
               do_end = (field_ff != FN_DONE);
            end else if (field_ff != FN_DONE) begin
               if (tok_len_ff == TL_MAX) begin
                  error_in = ERR_TOKEN_LONG;
               end else begin
                  tok_len_in = tok_len_ff + TLW'(1);
                  case (magic_ff)
                     MP_NONE: magic_in = (ch == CH_P) ? MP_P : MP_BAD;
                     MP_P:    magic_in = (ch == CH_4) ? MP_P4 : MP_BAD;
                     default: magic_in = MP_BAD;
                  endcase
                  if (!flags_ff.stop) begin
                     if (ch inside {[CH_0:CH_9]}) begin
                        flags_in.begun = 1'b1;
                        if (!flags_ff.ovf) begin
                           if (num_next > PW'(MAX_DIM)) begin
                              flags_in.ovf = 1'b1;
                           end else begin
                              num_in = num_next[NVW-1:0];
                           end
                        end
                     end else if (!flags_ff.begun && (ch inside {CH_VT, CH_FF})) begin
                        flags_in = flags_ff;
                     end else if (!flags_ff.begun && (ch inside {CH_PLUS, CH_MINUS})) begin
                        flags_in.begun = 1'b1;
                        flags_in.neg   = (ch == CH_MINUS);
                     end else begin
                        flags_in.stop = 1'b1;
                     end
                  end
               end
            end else if (header_done_ff) begin
               in_bitmap_in = 1'b1;
               to_data      = 1'b1;
            end
         end
      end

      if (do_end && (tok_len_ff != '0)) begin
         magic_good_in  = et_magic_good;
         width_ok_in    = et_width_ok;
         header_done_in = et_header_done;
         required_in    = et_required;
         error_in       = et_error;
         tok_len_in     = '0;
         magic_in       = MP_NONE;
         num_in         = '0;
         flags_in       = '0;
         if (field_ff != FN_DONE) begin
            field_in = field_ff + 2'd1;
         end
      end

      if (to_data && (stored_ff < required_ff)) begin
         result.data_valid = 1'b1;
         result.data_byte  = ch;
         result.data_index = stored_ff[INDEX_W-1:0];
         stored_in         = stored_ff + CAP_W'(1);
      end

      result.header_good = header_done_in;
      if (req_kind == KIND_EOS) begin
         if (error_in != ERR_NONE) begin
            code = error_in;
         end else if (!header_done_in) begin
            code = ERR_NO_HEADER;
         end else if (stored_ff != required_in) begin
            code = ERR_INCOMPLETE;
         end else begin
            result.success = 1'b1;
         end
         result.error_code    = code;
         result.verdict_valid = 1'b1;
      end else begin
         result.error_code = error_in;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (accept) begin
         if (out_free) begin
            out_valid_in = 1'b1;
            out_in       = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = result;
         end
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_width_ff  <= DIM_W'(1);
         exp_height_ff <= DIM_W'(1);
         capacity_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WIDTH:    exp_width_ff  <= csr_write_data[DIM_W-1:0];
            CSR_HEIGHT:   exp_height_ff <= csr_write_data[DIM_W-1:0];
            CSR_CAPACITY: capacity_ff   <= csr_write_data[CAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_comment_ff  <= 1'b0;
         field_ff       <= FN_MAGIC;
         tok_len_ff     <= '0;
         magic_ff       <= MP_NONE;
         num_ff         <= '0;
         flags_ff       <= '0;
         magic_good_ff  <= 1'b0;
         width_ok_ff    <= 1'b0;
         header_done_ff <= 1'b0;
         in_bitmap_ff   <= 1'b0;
         stored_ff      <= '0;
         required_ff    <= '0;
         error_ff       <= ERR_NONE;
      end else if (accept) begin
         in_comment_ff  <= in_comment_in;
         field_ff       <= field_in;
         tok_len_ff     <= tok_len_in;
         magic_ff       <= magic_in;
         num_ff         <= num_in;
         flags_ff       <= flags_in;
         magic_good_ff  <= magic_good_in;
         width_ok_ff    <= width_ok_in;
         header_done_ff <= header_done_in;
         in_bitmap_ff   <= in_bitmap_in;
         stored_ff      <= stored_in;
         required_ff    <= required_in;
         error_ff       <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_data_valid    = out_ff.data_valid;
   assign rsp_data_byte     = out_ff.data_byte;
   assign rsp_data_index    = out_ff.data_index;
   assign rsp_header_good   = out_ff.header_good;
   assign rsp_error_code    = out_ff.error_code;
   assign rsp_verdict_valid = out_ff.verdict_valid;
   assign rsp_success       = out_ff.success;

endmodule

`default_nettype wire

@@ design/pbm_checker.sv @@
// ============================================================================
// pbm_checker
// Port-level checks for the PBM header stream parser, bound to the top level.
// ============================================================================
`default_nettype none

module pbm_checker
   import pbm_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic                  rsp_data_valid,
   input wire logic [7:0]            rsp_data_byte,
   input wire logic [INDEX_W-1:0]    rsp_data_index,
   input wire logic                  rsp_header_good,
   input wire logic [ERR_W-1:0]      rsp_error_code,
   input wire logic                  rsp_verdict_valid,
   input wire logic                  rsp_success
);

   // no response straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_valid)
         && $stable(rsp_data_byte) && $stable(rsp_data_index)
         && $stable(rsp_error_code) && $stable(rsp_verdict_valid)
         && $stable(rsp_success))
      else $error("stalled response changed");

   // bitmap bytes only after a good header and never on the verdict
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_valid |->
         rsp_header_good && rsp_error_code == ERR_NONE && !rsp_verdict_valid)
      else $error("bitmap byte without good header");

   // success only as a clean verdict
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_success |->
         rsp_verdict_valid && rsp_header_good && rsp_error_code == ERR_NONE)
      else $error("success outside a clean verdict");

   // a full skid stage means a response is pending
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

endmodule

bind pbm_p4_header_stream_parser pbm_checker u_pbm_checker (.*);

`default_nettype wire

@@ dv/pbm_p4_header_stream_parser_tb.sv @@
// ============================================================================
// pbm_p4_header_stream_parser_tb
// Sends one byte stream through the parser: a PBM (P4) header built with
// random spacing, comments and number decoration (sometimes deliberately
// broken), then random bitmap bytes with end-of-stream requests mixed in.
// A predictor tracks tokens, checks and routed bytes, and each response is
// compared field by field, under phases of sender idling, receiver stalls
// and one long receiver hold-off.
// ============================================================================

module pbm_p4_header_stream_parser_tb;
   import pbm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 50;

   typedef struct {
      logic       kind;
      logic [7:0] value;
   } stream_item_type;

   typedef enum {
      HDR_GOOD, HDR_BAD_MAGIC, HDR_SIZE, HDR_TOO_SMALL, HDR_TOKEN_LONG
   } header_case_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index = CSR_WIDTH;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_kind = KIND_BYTE;
   logic [7:0]            req_byte_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_data_valid;
   logic [7:0]            rsp_data_byte;
   logic [INDEX_W-1:0]    rsp_data_index;
   logic                  rsp_header_good;
   logic [ERR_W-1:0]      rsp_error_code;
   logic                  rsp_verdict_valid;
   logic                  rsp_success;

   pbm_p4_header_stream_parser u_top (.*);

   always #2 clock = ~clock;

   stream_item_type stream_queue [$];
   rsp_type         pending_results [$];
   header_case_type header_case;

   int   send_idle_pct = 0;
   int   stall_pct = 0;
   int   hold_ticket = 0;
   int   hold_seen = 0;
   int   hold_left = 0;
   logic req_taken = 1'b0;
   int   quiet_cycles = 0;
   int   failures = 0;
   int   accepted_requests = 0;
   int   sent_requests = 0;
   int   checked_responses = 0;
   int   routed_bytes = 0;
   int   verdict_count = 0;
   int   success_count = 0;
   int   back_pressure_cycles = 0;

   // --- parser model ---------------------------------------------------------
   logic [DIM_W-1:0] cfg_width;
   logic [DIM_W-1:0] cfg_height;
   logic [CAP_W-1:0] cfg_capacity;
   logic             comment_open;
   logic [1:0]       field_sel;
   logic [4:0]       tok_len;
   logic [1:0]       magic_state;
   logic [DIM_W-1:0] num_value;
   num_flags_type    num_flags;
   logic             magic_ok;
   logic             width_ok;
   logic             header_ok;
   logic             bitmap_open;
   logic [CAP_W-1:0] stored_count;
   logic [CAP_W-1:0] required_count;
   logic [ERR_W-1:0] sticky_code;

   function void clear_parser_model();
      cfg_width      = DIM_W'(1);
      cfg_height     = DIM_W'(1);
      cfg_capacity   = '0;
      comment_open   = 1'b0;
      field_sel      = FN_MAGIC;
      tok_len        = '0;
      magic_state    = MP_NONE;
      num_value      = '0;
      num_flags      = '0;
      magic_ok       = 1'b0;
      width_ok       = 1'b0;
      header_ok      = 1'b0;
      bitmap_open    = 1'b0;
      stored_count   = '0;
      required_count = '0;
      sticky_code    = ERR_NONE;
   endfunction

   function void note_error(logic [ERR_W-1:0] code);
      if (sticky_code == ERR_NONE) sticky_code = code;
   endfunction

   function logic number_matches(logic [DIM_W-1:0] want);
      if (num_flags.ovf) return 1'b0;
      if (num_flags.neg && num_value != 0) return 1'b0;
      return num_value == want;
   endfunction

   function void take_token_char(logic [7:0] c);
      int v;
      case (magic_state)
         MP_NONE: magic_state = (c == CH_P) ? MP_P : MP_BAD;
         MP_P:    magic_state = (c == CH_4) ? MP_P4 : MP_BAD;
         default: magic_state = MP_BAD;
      endcase
      if (num_flags.stop) return;
      if (c >= CH_0 && c <= CH_9) begin
         num_flags.begun = 1'b1;
         if (!num_flags.ovf) begin
            v = int'(num_value) * 10 + int'(c - CH_0);
            if (v > MAX_DIM_DEFAULT) num_flags.ovf = 1'b1;
            else num_value = v[DIM_W-1:0];
         end
      end else if (!num_flags.begun && (c == CH_VT || c == CH_FF)) begin
         // leading space inside the token
      end else if (!num_flags.begun && (c == CH_PLUS || c == CH_MINUS)) begin
         num_flags.begun = 1'b1;
         if (c == CH_MINUS) num_flags.neg = 1'b1;
      end else begin
         num_flags.stop = 1'b1;
      end
   endfunction

   function void close_token();
      int need;
      if (tok_len == 0) return;
      case (field_sel)
         FN_MAGIC: magic_ok = (magic_state == MP_P4);
         FN_WIDTH: width_ok = number_matches(cfg_width);
         FN_HEIGHT: begin
            if (!magic_ok) begin
               note_error(ERR_BAD_MAGIC);
            end else if (!width_ok || !number_matches(cfg_height)) begin
               note_error(ERR_SIZE);
            end else begin
               need = ((int'(cfg_width) + 7) / 8) * int'(cfg_height);
               required_count = need[CAP_W-1:0];
               if (int'(cfg_capacity) < need) note_error(ERR_TOO_SMALL);
               else header_ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
      tok_len     = '0;
      magic_state = MP_NONE;
      num_value   = '0;
      num_flags   = '0;
      if (field_sel != FN_DONE) field_sel = field_sel + 2'd1;
   endfunction

   function rsp_type parse_request(logic kind, logic [7:0] c);
      rsp_type r;
      logic    to_data;
      r = '0;
      if (kind == KIND_EOS) begin
         if (!bitmap_open && sticky_code == ERR_NONE) close_token();
         r.verdict_valid = 1'b1;
         r.header_good   = header_ok;
         if (sticky_code != ERR_NONE) r.error_code = sticky_code;
         else if (!header_ok) r.error_code = ERR_NO_HEADER;
         else if (stored_count != required_count) r.error_code = ERR_INCOMPLETE;
         else r.success = 1'b1;
         return r;
      end
      if (sticky_code == ERR_NONE) begin
         to_data = bitmap_open;
         if (!bitmap_open) begin
            if (comment_open) begin
               if (c == CH_LF || c == CH_CR) comment_open = 1'b0;
            end else if (c == CH_HASH) begin
               close_token();
               comment_open = 1'b1;
            end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
               if (field_sel != FN_DONE) close_token();
            end else if (field_sel != FN_DONE) begin
               if (int'(tok_len) + 1 >= TOKEN_BUF_DEFAULT) begin
                  note_error(ERR_TOKEN_LONG);
               end else begin
                  take_token_char(c);
                  tok_len = tok_len + 5'd1;
               end
            end else if (header_ok) begin
               bitmap_open = 1'b1;
               to_data     = 1'b1;
            end
         end
         if (to_data && stored_count < required_count) begin
            r.data_valid = 1'b1;
            r.data_byte  = c;
            r.data_index = stored_count[INDEX_W-1:0];
            stored_count = stored_count + CAP_W'(1);
         end
      end
      r.header_good = header_ok;
      r.error_code  = sticky_code;
      return r;
   endfunction

   function void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         failures++;
      end
   endfunction

   // --- model update and response check -------------------------------------
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         clear_parser_model();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_data_valid, rsp_data_byte, rsp_data_index, rsp_header_good,
                   rsp_error_code, rsp_verdict_valid, rsp_success};
            if (got.data_valid) routed_bytes++;
            if (got.verdict_valid) verdict_count++;
            if (got.success) success_count++;
            if (pending_results.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               want = pending_results.pop_front();
               checked_responses++;
               check_field("data_valid", want.data_valid, got.data_valid);
               check_field("data_byte", want.data_byte, got.data_byte);
               check_field("data_index", want.data_index, got.data_index);
               check_field("header_good", want.header_good, got.header_good);
               check_field("error_code", want.error_code, got.error_code);
               check_field("verdict_valid", want.verdict_valid, got.verdict_valid);
               check_field("success", want.success, got.success);
            end
         end
         if (req_valid && !req_stall) begin
            pending_results.push_back(parse_request(req_kind, req_byte_value));
            accepted_requests++;
         end
         if (req_valid && req_stall) back_pressure_cycles++;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_WIDTH:    cfg_width = csr_write_data[DIM_W-1:0];
               CSR_HEIGHT:   cfg_height = csr_write_data[DIM_W-1:0];
               CSR_CAPACITY: cfg_capacity = csr_write_data[CAP_W-1:0];
               default: begin
               end
            endcase
         end
      end
      req_taken <= !reset && req_valid && !req_stall;
   end

   // --- request driver ------------------------------------------------------
   always @(negedge clock) begin
      stream_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (stream_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            item = stream_queue.pop_front();
            sent_requests++;
            req_valid      <= 1'b1;
            req_kind       <= item.kind;
            req_byte_value <= item.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // --- response stall ------------------------------------------------------
   always @(negedge clock) begin
      if (hold_seen != hold_ticket) begin
         hold_seen <= hold_ticket;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // --- watchdog ------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("no request or response moved for %0d cycles", WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // --- stimulus ------------------------------------------------------------
   task automatic push_byte(logic [7:0] b);
      stream_queue.push_back('{KIND_BYTE, b});
   endtask

   task automatic push_end();
      stream_queue.push_back('{KIND_EOS, 8'($urandom_range(0, 255))});
   endtask

   task automatic push_text(string s);
      foreach (s[i]) push_byte(s[i]);
   endtask

   task automatic push_gap();
      logic [7:0] seps [4];
      int         mode;
      seps = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
      mode = $urandom_range(0, 3);
      if (mode != 0) push_byte(seps[$urandom_range(0, 3)]);
      if (mode <= 1) begin
         push_byte(CH_HASH);
         repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(33, 126)));
         push_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
      end
      if ($urandom_range(0, 3) == 0) push_byte(seps[$urandom_range(0, 3)]);
   endtask

   task automatic push_number(int value);
      if ($urandom_range(0, 3) == 0) push_byte($urandom_range(0, 1) ? CH_VT : CH_FF);
      if ($urandom_range(0, 3) == 0) push_byte(CH_PLUS);
      repeat ($urandom_range(0, 2)) push_byte(CH_0);
      push_text($sformatf("%0d", value));
      // trailing junk stops the number
      if ($urandom_range(0, 3) == 0) begin
         if ($urandom_range(0, 1)) push_byte(8'd0);
         else push_text("x");
      end
   endtask

   task automatic push_random_traffic(int count);
      repeat (count) begin
         if ($urandom_range(0, 19) == 0) push_end();
         else push_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic write_register(logic [CSR_ADDR_W-1:0] idx, int value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic drain();
      while (stream_queue.size() != 0 || sent_requests != checked_responses)
         @(negedge clock);
   endtask

   initial begin
      int pick;
      int hdr_width;
      int hdr_height;
      int need;
      int capacity;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      pick = $urandom_range(0, 11);
      case (pick)
         8:       header_case = HDR_BAD_MAGIC;
         9:       header_case = HDR_SIZE;
         10:      header_case = HDR_TOO_SMALL;
         11:      header_case = HDR_TOKEN_LONG;
         default: header_case = HDR_GOOD;
      endcase
      if ($urandom_range(0, 3) == 0) begin
         hdr_width  = MAX_DIM_DEFAULT;
         hdr_height = 1;
      end else begin
         hdr_width  = $urandom_range(1, 64);
         hdr_height = $urandom_range(1, 40);
      end
      need = ((hdr_width + 7) / 8) * hdr_height;
      if (header_case == HDR_TOO_SMALL) capacity = need - 1;
      else if ($urandom_range(0, 3) == 0) capacity = 2097152;
      else capacity = need + $urandom_range(0, 2);

      write_register(CSR_WIDTH, MAX_DIM_DEFAULT);
      write_register(CSR_HEIGHT, MAX_DIM_DEFAULT);
      write_register(CSR_CAPACITY, 2097152);
      write_register(CSR_WIDTH, hdr_width);
      write_register(CSR_HEIGHT, hdr_height);
      write_register(CSR_CAPACITY, capacity);

      // header, full rate both ways
      send_idle_pct = 0;
      stall_pct     = 0;
      push_end();
      if ($urandom_range(0, 1)) push_gap();
      if (header_case == HDR_BAD_MAGIC) begin
         case ($urandom_range(0, 3))
            0: push_text("P5");
            1: begin
               push_text("P4");
               push_byte(8'd0);
            end
            2: push_text("p4");
            default: push_text("P44");
         endcase
      end else begin
         push_text("P4");
      end
      if ($urandom_range(0, 1)) push_end();
      push_gap();
      case (header_case)
         HDR_SIZE: begin
            case ($urandom_range(0, 3))
               0: push_number(hdr_width == MAX_DIM_DEFAULT ? hdr_width - 1 : hdr_width + 1);
               1: push_text($sformatf("-%0d", hdr_width));
               2: push_text("99999");
               default: push_text("-0");
            endcase
         end
         HDR_TOKEN_LONG: repeat (TOKEN_BUF_DEFAULT) push_text("7");
         default: push_number(hdr_width);
      endcase
      if ($urandom_range(0, 1)) push_end();
      push_gap();
      push_number(hdr_height);
      push_gap();
      push_random_traffic(20);
      drain();
      repeat (3) @(negedge clock);
      write_register(CSR_CAPACITY, 0);

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 80;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 0;
               stall_pct     = 80;
            end
            default: begin
               send_idle_pct = 6;
               stall_pct     = 6;
            end
         endcase
         push_random_traffic(170);
         drain();
         repeat (3) @(negedge clock);
         if (p == 0) write_register(CSR_WIDTH, 1);
         else if (p == 1) write_register(CSR_HEIGHT, 1);
      end

      // long receiver hold-off with the sender running flat out
      send_idle_pct = 0;
      stall_pct     = 0;
      push_random_traffic(170);
      hold_ticket++;
      drain();
      repeat (10) @(negedge clock);

      $display("Header case %s (%0d x %0d, capacity %0d): %0d requests, %0d bitmap bytes routed",
               header_case.name(), hdr_width, hdr_height, capacity, accepted_requests,
               routed_bytes);
      $display("%0d verdicts, %0d successful; input held back on %0d cycles",
               verdict_count, success_count, back_pressure_cycles);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
